// ===== hdl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg
// Shared widths, codes and defaults for the substring highlight stream unit.
// ----------------------------------------------------------------------------
package shs_pkg;

  // longest pattern the window can hold
  localparam int MAX_PATTERN_DEFAULT = 8;

  localparam int BYTE_W     = 8;
  localparam int PATTERN_W  = 64;
  localparam int LENGTH_W   = 4;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PATTERN_W;

  localparam logic [BYTE_W-1:0] LINE_BREAK = 8'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

endpackage

// ===== hdl/shs_stream_if.sv =====
// ----------------------------------------------------------------------------
// shs_text_if / shs_result_if
// Valid/ready channels for text bytes in and highlighted bytes out.
// ----------------------------------------------------------------------------
interface shs_text_if;
  logic                          valid;
  logic                          ready;
  logic [shs_pkg::BYTE_W-1:0]    text_byte;
  logic                          end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface shs_result_if;
  logic                          valid;
  logic                          ready;
  logic [shs_pkg::BYTE_W-1:0]    out_byte;
  logic                          highlighted;
  logic                          last_of_run;
  logic [shs_pkg::TOTAL_W-1:0]   match_total;

  modport source (output valid, output out_byte, output highlighted, output last_of_run,
                  output match_total, input ready);
  modport sink   (input valid, input out_byte, input highlighted, input last_of_run,
                  input match_total, output ready);
endinterface

// ===== hdl/substring_highlight_stream_unit.sv =====
// ----------------------------------------------------------------------------
// substring_highlight_stream_unit
// Streams text bytes through and flags leftmost, non-overlapping matches of a
// configured pattern of up to MAX_PATTERN bytes; matches never cross a newline.
// ----------------------------------------------------------------------------
// Usage:
//   text_in carries one text byte per beat plus an end_of_text flag that
//   flushes everything still pending. result_out gives released bytes in
//   their original order, each with a highlight flag, a last_of_run flag on
//   the final beat caused by one input beat, and the saturating match count.
//   Pattern and length are written over cfg_we/cfg_index/cfg_data while the
//   block is idle; length zero turns matching off.
// Latency and throughput:
//   The pending window and the pattern compare are evaluated in the cycle a
//   text beat is taken; its results appear from the next cycle, one beat per
//   cycle while the receiver is ready, out of an output buffer of MAX_PATTERN
//   entries. A text beat that releases several bytes holds the output until
//   all of them have left, so the unit takes one text beat per cycle while
//   each releases at most one byte and the receiver is ready. The next text
//   beat is taken while the final result beat of the previous one leaves.
// Reset and stalls:
//   rst clears the pending window, the output buffer, the match count and
//   the configuration. A stalled receiver holds the current result beat and
//   text_in stops taking beats until the buffer drains.
// ----------------------------------------------------------------------------
module substring_highlight_stream_unit #(
  parameter int MAX_PATTERN = shs_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  shs_text_if.sink                        text_in,
  shs_result_if.source                    result_out,
  input  logic                            cfg_we,
  input  logic [shs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic [shs_pkg::PATTERN_W-1:0] pattern;
  logic [shs_pkg::LENGTH_W-1:0]  pattern_len;
  logic [shs_pkg::TOTAL_W-1:0]   match_count;

  logic [shs_pkg::BYTE_W-1:0]    win [MAX_PATTERN];
  logic [CW-1:0]                 win_count;

  logic [shs_pkg::BYTE_W-1:0]    ob_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]        ob_hl;
  logic [CW-1:0]                 ob_count;

  logic [shs_pkg::BYTE_W-1:0]    ext [MAX_PATTERN];
  logic [shs_pkg::BYTE_W-1:0]    win_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]        hl_next;
  logic [CW-1:0]                 fill;
  logic [CW-1:0]                 len_eff;
  logic [CW-1:0]                 drop;
  logic [CW-1:0]                 shift;
  logic                          is_break;
  logic                          full;
  logic                          hit;
  logic                          in_take;
  logic                          out_pop;

  assign in_take = text_in.valid && text_in.ready;
  assign out_pop = result_out.valid && result_out.ready;

  // take a new beat once the buffer is empty or its final beat leaves now
  assign text_in.ready = (ob_count == '0) || ((ob_count == CW'(1)) && result_out.ready);

  assign result_out.valid       = (ob_count != '0);
  assign result_out.out_byte    = ob_byte[0];
  assign result_out.highlighted = ob_hl[0];
  assign result_out.last_of_run = (ob_count == CW'(1));
  assign result_out.match_total = match_count;

  assign fill     = win_count + CW'(1);
  assign len_eff  = (pattern_len > shs_pkg::LENGTH_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN)
                                                                    : CW'(pattern_len);
  assign drop     = fill - len_eff;
  assign is_break = (text_in.text_byte == shs_pkg::LINE_BREAK);
  assign full     = (len_eff != '0) && (fill >= len_eff);

  // window with the arriving byte appended after the pending ones
  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      ext[j] = (CW'(j) < win_count) ? win[j] : text_in.text_byte;
    end
  end

  // compare the newest len_eff bytes with the pattern
  always_comb begin
    hit = full && !is_break;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (CW'(i) < len_eff) begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
          if (({1'b0, drop} + (CW+1)'(i)) == (CW+1)'(j)) begin
            if (ext[j] != pattern[8*i +: 8]) begin
              hit = 1'b0;
            end
          end
        end
      end
    end
  end

  // how many bytes leave the window in this step
  always_comb begin
    if (is_break || (len_eff == '0) || hit || text_in.end_of_text) begin
      shift = fill;
    end else if (full) begin
      shift = drop + CW'(1);
    end else begin
      shift = '0;
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      hl_next[j] = hit && (CW'(j) >= drop);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_next[i] = ext[i];
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (({1'b0, shift} + (CW+1)'(i)) == (CW+1)'(j)) begin
          win_next[i] = ext[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      pattern_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        shs_pkg::CFG_PATTERN_BYTES:  pattern     <= cfg_data;
        shs_pkg::CFG_PATTERN_LENGTH: pattern_len <= cfg_data[shs_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_count   <= '0;
      match_count <= '0;
    end else if (in_take) begin
      win_count <= fill - shift;
      if (hit && (match_count != '1)) begin
        match_count <= match_count + shs_pkg::TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_count <= '0;
    end else if (in_take) begin
      ob_count <= shift;
    end else if (out_pop) begin
      ob_count <= ob_count - CW'(1);
    end
  end

  // output buffer shifts toward entry 0 as beats leave
  always_ff @(posedge clk) begin
    if (in_take) begin
      ob_byte <= ext;
      ob_hl   <= hl_next;
    end else if (out_pop) begin
      for (int j = 0; j < MAX_PATTERN - 1; j++) begin
        ob_byte[j] <= ob_byte[j+1];
      end
      ob_hl <= ob_hl >> 1;
    end
  end

endmodule

// ===== hdl/shs_checker.sv =====
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on the substring highlight stream unit, bound to the top.
// ----------------------------------------------------------------------------
module shs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          last_of_run,
  input logic [shs_pkg::TOTAL_W-1:0]   match_total
);

  // count moves only after a text beat was taken
  a_total_needs_input: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(in_valid && in_ready) |-> $stable(match_total))
    else $error("match_total changed without a text beat");

  // one match at most per text beat
  a_total_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (match_total == $past(match_total)) ||
                    (match_total == $past(match_total) + shs_pkg::TOTAL_W'(1)))
    else $error("match_total moved by more than one");

  // no new text beat while earlier results are still queued behind this one
  a_ready_drained: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || (last_of_run && out_ready))
    else $error("text beat taken while results still pending");

  // final result beat leaves and nothing new came in: output goes idle
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_of_run && !(in_valid && in_ready) |=> !out_valid)
    else $error("result beat after the final one of a run");

endmodule

bind substring_highlight_stream_unit shs_checker u_shs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (text_in.valid),
  .in_ready    (text_in.ready),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .last_of_run (result_out.last_of_run),
  .match_total (result_out.match_total)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for substring_highlight_stream_unit: a scoreboard class
// keeps its own pending window, pattern and match count, predicts every
// released byte for each accepted text beat, and checks the result channel
// beat by beat while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MAX_PAT      = shs_pkg::MAX_PATTERN_DEFAULT;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHASE_BEATS  = 49;
  localparam int unsigned HOLD_CYCLES  = 120;
  localparam realtime     LIMIT_NS     = 3_000_000;

  typedef struct packed {
    logic [shs_pkg::BYTE_W-1:0]  out_byte;
    logic                        highlighted;
    logic                        last_of_run;
    logic [shs_pkg::TOTAL_W-1:0] match_total;
  } release_t;

  class highlight_scoreboard;
    logic [shs_pkg::PATTERN_W-1:0] pat;
    logic [shs_pkg::LENGTH_W-1:0]  plen;
    logic [shs_pkg::BYTE_W-1:0]    win [MAX_PAT];
    int unsigned                   wcount;
    logic [shs_pkg::TOTAL_W-1:0]   total;
    release_t                      due [$];
    int unsigned                   faults;
    int unsigned                   beats_seen;
    int unsigned                   lit_seen;

    function new();
      pat        = '0;
      plen       = '0;
      wcount     = 0;
      total      = '0;
      faults     = 0;
      beats_seen = 0;
      lit_seen   = 0;
    endfunction

    function void set_pattern(logic [shs_pkg::PATTERN_W-1:0] p,
                              logic [shs_pkg::LENGTH_W-1:0] l);
      pat  = p;
      plen = l;
    endfunction

    function bit window_hit(int unsigned len);
      for (int unsigned i = 0; i < len; i++)
        if (win[i] != pat[8*i +: 8]) return 1'b0;
      return 1'b1;
    endfunction

    function void flush_plain(ref release_t step[$]);
      for (int unsigned i = 0; i < wcount; i++)
        step.push_back('{win[i], 1'b0, 1'b0, '0});
      wcount = 0;
    endfunction

    // predict the bytes released by one accepted text beat
    function void note_text(logic [shs_pkg::BYTE_W-1:0] b, logic eot);
      release_t    step [$];
      int unsigned len;
      len = (plen > MAX_PAT) ? MAX_PAT : plen;
      if (b == shs_pkg::LINE_BREAK) begin
        flush_plain(step);
        step.push_back('{b, 1'b0, 1'b0, '0});
      end else begin
        win[wcount] = b;
        wcount++;
        while (wcount > 0 && wcount >= len) begin
          if (len > 0 && wcount == len && window_hit(len)) begin
            for (int unsigned i = 0; i < len; i++)
              step.push_back('{win[i], 1'b1, 1'b0, '0});
            wcount = 0;
            if (total != '1) total++;
          end else begin
            step.push_back('{win[0], 1'b0, 1'b0, '0});
            for (int unsigned i = 1; i < wcount; i++) win[i-1] = win[i];
            wcount--;
          end
        end
        if (eot) flush_plain(step);
      end
      foreach (step[k]) begin
        step[k].match_total = total;
        step[k].last_of_run = (k == step.size() - 1);
        due.push_back(step[k]);
      end
    endfunction

    function void check_release(release_t got);
      release_t want;
      beats_seen++;
      if (got.highlighted === 1'b1) lit_seen++;
      if (due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected beat byte=%h hl=%b last=%b total=%0d", $realtime,
                   got.out_byte, got.highlighted, got.last_of_run, got.match_total);
        return;
      end
      want = due.pop_front();
      if (got.out_byte !== want.out_byte || got.highlighted !== want.highlighted ||
          got.last_of_run !== want.last_of_run || got.match_total !== want.match_total) begin
        faults++;
        if (faults <= 10)
          $display({"%0t: mismatch exp byte=%h hl=%b last=%b total=%0d",
                    " / got byte=%h hl=%b last=%b total=%0d"},
                   $realtime, want.out_byte, want.highlighted, want.last_of_run,
                   want.match_total, got.out_byte, got.highlighted, got.last_of_run,
                   got.match_total);
      end
    endfunction
  endclass

  bit                             clk;
  logic                           rst = 1'b1;
  logic                           cfg_we;
  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data;

  shs_text_if   txt ();
  shs_result_if res ();

  substring_highlight_stream_unit dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (txt),
    .result_out (res),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  highlight_scoreboard sb;
  bit          quiet;
  bit          held_once;
  int unsigned beats_sent;
  int unsigned settings;
  release_t    rx_beat;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic push_text(input logic [shs_pkg::BYTE_W-1:0] b, input logic eot);
    while (!quiet && $urandom_range(0, 99) < 29) begin
      txt.valid <= 1'b0;
      @(negedge clk);
    end
    txt.valid       <= 1'b1;
    txt.text_byte   <= b;
    txt.end_of_text <= eot;
    do @(posedge clk); while (txt.ready !== 1'b1);
    sb.note_text(b, eot);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic push_string(input string s);
    for (int i = 0; i < s.len(); i++) push_text(s[i], 1'b0);
  endtask

  // registers may only change once every released byte has left
  task automatic wait_drain();
    txt.valid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_pattern(input logic [shs_pkg::PATTERN_W-1:0] p,
                                 input logic [shs_pkg::LENGTH_W-1:0] l);
    cfg_we    <= 1'b1;
    cfg_index <= shs_pkg::CFG_PATTERN_BYTES;
    cfg_data  <= p;
    @(negedge clk);
    cfg_index <= shs_pkg::CFG_PATTERN_LENGTH;
    cfg_data  <= shs_pkg::CFG_DATA_W'(l);
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_pattern(p, l);
    settings++;
  endtask

  function automatic logic [shs_pkg::BYTE_W-1:0] pick_byte(
      logic [shs_pkg::PATTERN_W-1:0] p, int unsigned len);
    int unsigned r;
    int unsigned pos;
    r = $urandom_range(0, 99);
    if (len > 0 && r < 50) begin
      pos = $urandom_range(0, len - 1);
      return p[8*pos +: 8];
    end
    if (r < 58) return shs_pkg::LINE_BREAK;
    return shs_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  // result side: sample at the rising edge
  always @(posedge clk) begin
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      rx_beat = '{res.out_byte, res.highlighted, res.last_of_run, res.match_total};
      sb.check_release(rx_beat);
    end
  end

  // receiver: random back-pressure plus one long hold while text keeps coming
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_once && sb.beats_seen >= 200 && txt.valid === 1'b1) begin
        held_once = 1'b1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res.ready <= !(!quiet && $urandom_range(0, 99) < 29);
      @(negedge clk);
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [shs_pkg::PATTERN_W-1:0] pat;
    int unsigned                   plen;
    int unsigned                   eff;
    int unsigned                   taken;
    int unsigned                   r;

    txt.valid       = 1'b0;
    txt.text_byte   = '0;
    txt.end_of_text = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = shs_pkg::CFG_PATTERN_BYTES;
    cfg_data        = '0;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: empty pattern, every byte goes straight through
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b1);
    wait_drain();

    // three-byte pattern of the byte extremes 00 and FF plus 41
    program_pattern(64'h0000_0000_0041_FF00, 4'd3);
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'h41, 1'b0);
    push_text(8'h00, 1'b0);
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b0);
    push_text(8'h41, 1'b0);
    push_text(8'h00, 1'b0);
    push_text(shs_pkg::LINE_BREAK, 1'b0);
    push_text(8'h00, 1'b0);
    push_text(8'hFF, 1'b1);
    wait_drain();

    // length above the window size acts as a full window
    program_pattern(64'h4847_4645_4443_4241, 4'd15);
    push_string("ABCDEFGH");
    wait_drain();

    // a pattern holding a line break never matches
    program_pattern({48'd0, shs_pkg::LINE_BREAK, 8'h78}, 4'd2);
    push_text(8'h78, 1'b0);
    push_text(shs_pkg::LINE_BREAK, 1'b0);
    wait_drain();

    // leave bytes pending, then shorten and change the pattern
    program_pattern(64'h0000_0065_6463_6261, 4'd5);
    push_string("abcd");
    wait_drain();
    program_pattern(64'h0000_0000_0000_6564, 4'd2);
    push_text(8'h65, 1'b0);
    wait_drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       plen = MAX_PAT;
        1:       plen = 1;
        2:       plen = 0;
        3:       plen = $urandom_range(MAX_PAT + 1, 15);
        default: plen = $urandom_range(1, MAX_PAT);
      endcase
      for (int i = 0; i < 8; i++) begin
        r = $urandom_range(0, 99);
        pat[8*i +: 8] = (r < 70) ? 8'h61 + shs_pkg::BYTE_W'($urandom_range(0, 2)) :
                        (r < 75) ? shs_pkg::LINE_BREAK :
                                   shs_pkg::BYTE_W'($urandom_range(0, 255));
      end
      quiet = (p == 4);
      wait_drain();
      program_pattern(pat, shs_pkg::LENGTH_W'(plen));
      eff   = (plen > MAX_PAT) ? MAX_PAT : plen;
      taken = 0;
      while (taken < PHASE_BEATS) begin
        if (eff > 0 && $urandom_range(0, 99) < 35) begin
          for (int unsigned i = 0; i < eff; i++)
            push_text(pat[8*i +: 8], (i == eff - 1) && ($urandom_range(0, 99) < 5));
          taken += eff;
        end else begin
          push_text(pick_byte(pat, eff), $urandom_range(0, 99) < 4);
          taken++;
        end
      end
    end
    quiet = 1'b0;
    wait_drain();

    $display("run covered %0d text beats under %0d pattern settings", beats_sent, settings);
    $display("%0d result beats checked, %0d highlighted, %0d matches, %0d mismatches",
             sb.beats_seen, sb.lit_seen, sb.total, sb.faults);
    if (sb.faults == 0 && sb.due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
